>>> hdl/fsmm_pkg.sv
package fsmm_pkg;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_COMPUTE = 1'b1;
    localparam logic [4:0] SIZE_RESET = 5'd16;

    typedef struct packed {
        logic        mode;
        logic [3:0]  row_index;
        logic [3:0]  col_index;
        logic [31:0] a_value;
        logic [31:0] b_value;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  result_col;
        logic [31:0] c_value;
        logic        last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_FLAST,
        ST_READ,
        ST_MUL,
        ST_NORM,
        ST_ALIGN,
        ST_SUM,
        ST_EMIT
    } state_t;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
            begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

endpackage

>>> hdl/float_square_matrix_multiply_top.sv
// Load words return nothing and leave the block idle; the next word is taken the cycle after.
// A compute word of size n is accepted, fills the row of A into the cells, then for each column
// runs READ, MUL, NORM, ALIGN and SUM for each k, and EMIT, which waits while the output is stalled.
// The row of A sits in a rotating chain of cells; results leave through one output register.
// rst_n is asynchronous and active low; it clears control state and sets the size to 16.
// The matrix stores are not cleared by reset.
module float_square_matrix_multiply_top #(
    parameter int MAX_N = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fsmm_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output fsmm_pkg::out_word_t out_word,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata
);
    import fsmm_pkg::*;

    localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1;
    localparam int DEPTH = 1 << AW;
    localparam int NW = $clog2(MAX_N + 1);

    state_t          state_reg, state_next;
    logic [4:0]      size_reg;
    logic [IW-1:0]   row_reg, row_next;
    logic [IW-1:0]   k_reg, k_next;
    logic [IW-1:0]   j_reg, j_next;
    logic            pend_reg;
    logic [31:0]     prod_reg;
    logic [31:0]     acc_reg, acc_next;
    logic            out_valid_reg, out_valid_next;
    out_word_t       out_word_reg, out_word_next;

    logic [NW-1:0]   n_eff;
    logic            k_last, j_last;
    logic            accept, load_ok, row_ok;
    logic [AW-1:0]   waddr, a_raddr, b_raddr;
    logic [31:0]     a_q, b_q;
    logic [31:0]     mul_y, add_y;
    logic [31:0]     cell_q [MAX_N];
    logic [31:0]     tail_in;
    logic            cell_en;

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(size_reg) > MAX_N)
        begin
            n_eff = NW'(MAX_N);
        end
        else
        begin
            n_eff = NW'(size_reg);
        end
    end

    assign k_last  = (32'(k_reg) == 32'(n_eff) - 1);
    assign j_last  = (32'(j_reg) == 32'(n_eff) - 1);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept  = in_valid && in_ready;
    assign load_ok = (32'(in_word.row_index) < MAX_N) && (32'(in_word.col_index) < MAX_N);
    assign row_ok  = 32'(in_word.row_index) < 32'(n_eff);
    assign waddr   = AW'(32'(in_word.row_index) * MAX_N + 32'(in_word.col_index));
    assign a_raddr = AW'(32'(row_reg) * MAX_N + 32'(k_reg));
    assign b_raddr = AW'(32'(k_reg) * MAX_N + 32'(j_reg));

    fsmm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (
        .clk   (clk),
        .we    (accept && (in_word.mode == MODE_LOAD) && load_ok),
        .waddr (waddr),
        .wdata (in_word.a_value),
        .raddr (a_raddr),
        .rdata (a_q)
    );

    fsmm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (
        .clk   (clk),
        .we    (accept && (in_word.mode == MODE_LOAD) && load_ok),
        .waddr (waddr),
        .wdata (in_word.b_value),
        .raddr (b_raddr),
        .rdata (b_q)
    );

    assign tail_in = pend_reg ? a_q : cell_q[0];
    assign cell_en = pend_reg || (state_reg == ST_SUM);

    for (genvar i = 0; i < MAX_N; i++)
    begin : g_cell
        logic [31:0] d_next;
        if (i == MAX_N - 1)
        begin : g_end
            assign d_next = tail_in;
        end
        else
        begin : g_mid
            assign d_next = cell_q[i + 1];
        end
        fsmm_cell u_cell (
            .clk      (clk),
            .en       (cell_en),
            .sel_tail (32'(i) == 32'(n_eff) - 1),
            .d_next   (d_next),
            .d_tail   (tail_in),
            .q        (cell_q[i])
        );
    end

    fsmm_fmul u_fmul (
        .clk (clk),
        .en  (state_reg == ST_MUL),
        .a   (cell_q[0]),
        .b   (b_q),
        .y   (mul_y)
    );

    fsmm_fadd u_fadd (
        .clk (clk),
        .en  (state_reg == ST_ALIGN),
        .a   (acc_reg),
        .b   (prod_reg),
        .y   (add_y)
    );

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_word.mode == MODE_COMPUTE) && row_ok)
                begin
                    row_next   = IW'(in_word.row_index);
                    k_next     = '0;
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_FLAST;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_FLAST:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                state_next = ST_ALIGN;
            end
            ST_ALIGN:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                acc_next = add_y;
                if (k_last)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_word_next.result_col = 4'(j_reg);
                    out_word_next.c_value    = acc_reg;
                    out_word_next.last       = j_last;
                    acc_next                 = '0;
                    k_next                   = '0;
                    if (j_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= SIZE_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= (state_reg == ST_FILL);
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        k_reg        <= k_next;
        j_reg        <= j_next;
        acc_reg      <= acc_next;
        out_word_reg <= out_word_next;
        if (state_reg == ST_NORM)
        begin
            prod_reg <= mul_y;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

>>> hdl/fsmm_ram.sv
module fsmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/fsmm_cell.sv
module fsmm_cell (
    input  logic        clk,
    input  logic        en,
    input  logic        sel_tail,
    input  logic [31:0] d_next,
    input  logic [31:0] d_tail,
    output logic [31:0] q
);

    logic [31:0] val_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= sel_tail ? d_tail : d_next;
        end
    end

    assign q = val_reg;

endmodule

>>> hdl/fsmm_fmul.sv
module fsmm_fmul (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);
    import fsmm_pkg::*;

    logic               sign_reg;
    logic               nan_reg;
    logic               inf_reg;
    logic               zero_reg;
    logic [47:0]        p_reg;
    logic signed [9:0]  e_reg;

    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [7:0]  ea_eff, eb_eff;

    assign a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    assign b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    assign a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    assign b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    assign a_zero = (a[30:0] == '0);
    assign b_zero = (b[30:0] == '0);
    assign ma     = {a[30:23] != '0, a[22:0]};
    assign mb     = {b[30:23] != '0, b[22:0]};
    assign ea_eff = (a[30:23] == '0) ? 8'd1 : a[30:23];
    assign eb_eff = (b[30:23] == '0) ? 8'd1 : b[30:23];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_reg <= a[31] ^ b[31];
            nan_reg  <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
            inf_reg  <= a_inf || b_inf;
            zero_reg <= a_zero || b_zero;
            p_reg    <= ma * mb;
            e_reg    <= $signed({2'b00, ea_eff}) + $signed({2'b00, eb_eff}) - 10'sd127;
        end
    end

    logic [5:0]        lz;
    logic signed [9:0] e_norm;
    logic signed [9:0] amt;
    logic [9:0]        rsh;
    logic [47:0]       norm;
    logic              st_r;
    logic [7:0]        expf;
    logic              inc;
    logic [30:0]       mag;

    always_comb
    begin
        lz     = lzc48(p_reg);
        e_norm = e_reg + 10'sd1 - $signed({4'b0000, lz});
        amt    = $signed({4'b0000, lz}) + e_norm - 10'sd1;
        rsh    = 10'(-amt);
        st_r   = 1'b0;
        expf   = '0;
        if (e_norm >= 10'sd1)
        begin
            norm = p_reg << lz;
            expf = e_norm[7:0];
        end
        else if (amt >= 10'sd0)
        begin
            norm = p_reg << amt[5:0];
        end
        else if (rsh >= 10'd48)
        begin
            norm = '0;
            st_r = |p_reg;
        end
        else
        begin
            norm = p_reg >> rsh[5:0];
            st_r = |(p_reg & ~({48{1'b1}} << rsh[5:0]));
        end
        inc = norm[23] && ((|norm[22:0]) || st_r || norm[24]);
        mag = {expf, norm[46:24]} + {30'd0, inc};
        if (nan_reg)
        begin
            y = CANON_NAN;
        end
        else if (inf_reg || (e_norm > 10'sd254))
        begin
            y = {sign_reg, 8'hFF, 23'd0};
        end
        else if (zero_reg)
        begin
            y = {sign_reg, 31'd0};
        end
        else
        begin
            y = {sign_reg, mag};
        end
    end

endmodule

>>> hdl/fsmm_fadd.sv
module fsmm_fadd (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);
    import fsmm_pkg::*;

    logic        a_nan, b_nan, a_inf, b_inf;
    logic        swap;
    logic [31:0] big, sml;
    logic [7:0]  eb_eff, es_eff, d;
    logic [26:0] mbig, msml, aligned;

    assign a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    assign b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    assign a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    assign b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    assign swap   = b[30:0] > a[30:0];
    assign big    = swap ? b : a;
    assign sml    = swap ? a : b;
    assign eb_eff = (big[30:23] == '0) ? 8'd1 : big[30:23];
    assign es_eff = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    assign d      = eb_eff - es_eff;
    assign mbig   = {big[30:23] != '0, big[22:0], 3'b000};
    assign msml   = {sml[30:23] != '0, sml[22:0], 3'b000};

    always_comb
    begin
        if (d >= 8'd27)
        begin
            aligned = {26'd0, |msml};
        end
        else
        begin
            aligned = msml >> d[4:0];
            aligned[0] = aligned[0] | (|(msml & ~({27{1'b1}} << d[4:0])));
        end
    end

    logic        sign_reg, sub_reg, nan_reg, inf_reg, inf_sign_reg, zz_reg, zz_sign_reg;
    logic [26:0] mb_reg, ms_reg;
    logic [7:0]  e_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_reg     <= big[31];
            sub_reg      <= a[31] ^ b[31];
            nan_reg      <= a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
            inf_reg      <= a_inf || b_inf;
            inf_sign_reg <= a_inf ? a[31] : b[31];
            zz_reg       <= (a[30:0] == '0) && (b[30:0] == '0);
            zz_sign_reg  <= a[31] & b[31];
            mb_reg       <= mbig;
            ms_reg       <= aligned;
            e_reg        <= eb_eff;
        end
    end

    logic [27:0] sum;
    logic [5:0]  lz;
    logic [8:0]  shift;
    logic [26:0] m;
    logic [8:0]  e_new;
    logic [7:0]  expf;
    logic        inc;
    logic [30:0] mag;

    always_comb
    begin
        sum   = sub_reg ? ({1'b0, mb_reg} - {1'b0, ms_reg}) : ({1'b0, mb_reg} + {1'b0, ms_reg});
        lz    = lzc48({sum[26:0], 21'd0});
        shift = ({3'b000, lz} < ({1'b0, e_reg} - 9'd1)) ? {3'b000, lz} : ({1'b0, e_reg} - 9'd1);
        if (sum[27])
        begin
            m     = {sum[27:2], sum[1] | sum[0]};
            e_new = {1'b0, e_reg} + 9'd1;
        end
        else
        begin
            m     = sum[26:0] << shift[4:0];
            e_new = {1'b0, e_reg} - shift;
        end
        expf = m[26] ? e_new[7:0] : 8'd0;
        inc  = m[2] && (m[1] || m[0] || m[3]);
        mag  = {expf, m[25:3]} + {30'd0, inc};
        if (nan_reg)
        begin
            y = CANON_NAN;
        end
        else if (inf_reg)
        begin
            y = {inf_sign_reg, 8'hFF, 23'd0};
        end
        else if (zz_reg)
        begin
            y = {zz_sign_reg, 31'd0};
        end
        else if (sum == '0)
        begin
            y = 32'd0;
        end
        else if (e_new >= 9'd255)
        begin
            y = {sign_reg, 8'hFF, 23'd0};
        end
        else
        begin
            y = {sign_reg, mag};
        end
    end

endmodule

>>> hdl/fsmm_checker.sv
module fsmm_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  fsmm_pkg::in_word_t  in_word,
    input  logic               out_valid,
    input  logic               out_ready,
    input  fsmm_pkg::out_word_t out_word
);
    import fsmm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed or dropped while stalled");

    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_word.mode == MODE_LOAD) |=> in_ready)
        else $error("load word did not finish in one cycle");

    a_row0_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_word.mode == MODE_COMPUTE)
        && (in_word.row_index == 4'd0) |=> !in_ready)
        else $error("compute of row zero did not start");

endmodule

bind float_square_matrix_multiply_top fsmm_checker u_fsmm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);
